// File: rtl/krt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// krt_pkg
// Shared types and constants of the keyed registration table.
// ----------------------------------------------------------------------------
package krt_pkg;

   localparam int unsigned TableEntriesDefault = 16;
   localparam int unsigned NameCharsDefault    = 10;
   localparam int unsigned NameWidth           = 80;
   localparam int unsigned PortWidth           = 16;
   localparam int unsigned CountWidth          = 5;
   localparam int unsigned QuotaReset          = 16;
   localparam int unsigned CsrAddrWidth        = 1;

   typedef enum logic [1:0] {
      ACT_REGISTER   = 2'd0,
      ACT_DEREGISTER = 2'd1,
      ACT_DEREG_ALL  = 2'd2,
      ACT_UNUSED     = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_ACK       = 2'd0,
      ST_QUOTA     = 2'd1,
      ST_DUPLICATE = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   localparam logic [CsrAddrWidth-1:0] CSR_ENTRY_QUOTA = '0;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEARCH,
      S_DECIDE,
      S_SHIFT,
      S_FILE_SCAN,
      S_DIST_SCAN,
      S_DIST_SHIFT,
      S_INSERT,
      S_RESPOND
   } state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;          // capture request word
      logic scan_clear;    // reset scan index and match flags
      logic scan_step;     // advance entry scan
      logic entry_append;  // write new entry at entry count
      logic shift_start;   // set shift index to found entry
      logic shift_step;    // move one entry down
      logic file_start;    // begin search of file among entries
      logic dist_start;    // begin search of distinct list
      logic dist_step;     // advance distinct scan
      logic dist_shift;    // move one distinct name down
      logic dist_append;   // add file to distinct list
      logic set_status;
      status_type status;
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic       scan_done;
      logic       pair_found;
      logic       client_found;
      logic       file_found;
      logic       dist_done;
      logic       dist_found;
      logic       shift_done;
      logic       dist_shift_done;
      logic       at_quota;
      logic       dist_full;
      action_type action;
   } stat_type;

endpackage : krt_pkg
`default_nettype wire

// File: rtl/krt_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// krt_req_if / krt_rsp_if
// Valid and ready channels of the keyed registration table.
// ----------------------------------------------------------------------------
interface krt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [63:0] client_name_lo;
   logic [15:0] client_name_hi;
   logic [63:0] file_name_lo;
   logic [15:0] file_name_hi;
   logic [63:0] address_lo;
   logic [15:0] address_hi;
   logic [15:0] listener_port;
   modport source (output valid, action, client_name_lo, client_name_hi, file_name_lo,
                   file_name_hi, address_lo, address_hi, listener_port, input ready);
   modport sink (input valid, action, client_name_lo, client_name_hi, file_name_lo,
                 file_name_hi, address_lo, address_hi, listener_port, output ready);
endinterface : krt_req_if

interface krt_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [4:0] entries_used;
   logic [4:0] distinct_files;
   modport source (output valid, status, entries_used, distinct_files, input ready);
   modport sink (input valid, status, entries_used, distinct_files, output ready);
endinterface : krt_rsp_if
`default_nettype wire

// File: rtl/krt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// krt_ctrl
// Sequencer that walks one request through search, compaction and the
// distinct list update.
// ----------------------------------------------------------------------------
module krt_ctrl
   import krt_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   state_type state_ff, state_in;
   state_type after_removal;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign after_removal = (stat.action == ACT_DEREG_ALL) ? S_SEARCH : S_RESPOND;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_SEARCH;
         end
         S_SEARCH: begin
            if (stat.scan_done) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            case (stat.action)
               ACT_REGISTER: begin
                  if (stat.at_quota || stat.pair_found) begin
                     state_in = S_RESPOND;
                  end else begin
                     state_in = S_DIST_SCAN;
                  end
               end
               ACT_DEREGISTER: begin
                  state_in = stat.pair_found ? S_SHIFT : S_RESPOND;
               end
               ACT_DEREG_ALL: begin
                  state_in = stat.client_found ? S_SHIFT : S_RESPOND;
               end
               default: state_in = S_RESPOND;
            endcase
         end
         S_SHIFT: begin
            if (stat.shift_done) state_in = S_FILE_SCAN;
         end
         S_FILE_SCAN: begin
            if (stat.scan_done) state_in = stat.file_found ? after_removal : S_DIST_SCAN;
         end
         S_DIST_SCAN: begin
            if (stat.dist_done) begin
               if (stat.action == ACT_REGISTER) begin
                  state_in = S_INSERT;
               end else if (stat.dist_found) begin
                  state_in = S_DIST_SHIFT;
               end else begin
                  state_in = after_removal;
               end
            end
         end
         S_DIST_SHIFT: begin
            if (stat.dist_shift_done) state_in = after_removal;
         end
         S_INSERT:  state_in = S_RESPOND;
         S_RESPOND: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.status = ST_ACK;
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready      = 1'b1;
            cmd.load       = req_valid;
            cmd.scan_clear = req_valid;
         end
         S_SEARCH: cmd.scan_step = 1'b1;
         S_DECIDE: begin
            cmd.set_status = 1'b1;
            case (stat.action)
               ACT_REGISTER: begin
                  if (stat.at_quota) begin
                     cmd.status = ST_QUOTA;
                  end else if (stat.pair_found) begin
                     cmd.status = ST_DUPLICATE;
                  end else begin
                     cmd.dist_start = 1'b1;
                  end
               end
               ACT_DEREGISTER: begin
                  cmd.status      = stat.pair_found ? ST_ACK : ST_NOT_FOUND;
                  cmd.shift_start = stat.pair_found;
               end
               ACT_DEREG_ALL: cmd.shift_start = stat.client_found;
               default: cmd.status = ST_NOT_FOUND;
            endcase
         end
         S_SHIFT: begin
            cmd.shift_step = 1'b1;
            cmd.file_start = stat.shift_done;
         end
         S_FILE_SCAN: begin
            cmd.scan_step  = 1'b1;
            cmd.dist_start = stat.scan_done && !stat.file_found;
            cmd.scan_clear = stat.scan_done && stat.file_found;
         end
         S_DIST_SCAN: begin
            cmd.dist_step  = 1'b1;
            cmd.scan_clear = stat.dist_done && stat.action != ACT_REGISTER
                             && !stat.dist_found;
         end
         S_DIST_SHIFT: begin
            cmd.dist_shift = 1'b1;
            cmd.scan_clear = stat.dist_shift_done;
         end
         S_INSERT: begin
            cmd.entry_append = 1'b1;
            cmd.dist_append  = !stat.dist_found && !stat.dist_full;
         end
         S_RESPOND: rsp_valid = 1'b1;
         default: ;
      endcase
   end

endmodule : krt_ctrl
`default_nettype wire

// File: rtl/krt_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// krt_datapath
// Entry table, distinct file list, scan and shift indexes, and compares.
// ----------------------------------------------------------------------------
module krt_datapath
   import krt_pkg::*;
#(
   parameter int unsigned TABLE_ENTRIES = TableEntriesDefault,
   parameter int unsigned NAME_CHARS    = NameCharsDefault
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output stat_type                   stat,
   input  wire logic [1:0]            in_action,
   input  wire logic [NameWidth-1:0]  in_client,
   input  wire logic [NameWidth-1:0]  in_file,
   input  wire logic [NameWidth-1:0]  in_address,
   input  wire logic [PortWidth-1:0]  in_port,
   input  wire logic [CountWidth-1:0] quota,
   output logic [1:0]                 out_status,
   output logic [CountWidth-1:0]      out_entries,
   output logic [CountWidth-1:0]      out_distinct
);

   localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
   localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);
   localparam int unsigned KeyW = (8 * NAME_CHARS < NameWidth) ? 8 * NAME_CHARS : NameWidth;

   logic [NameWidth-1:0] client_ff [TABLE_ENTRIES];
   logic [NameWidth-1:0] file_ff   [TABLE_ENTRIES];
   logic [NameWidth-1:0] addr_ff   [TABLE_ENTRIES];
   logic [PortWidth-1:0] port_ff   [TABLE_ENTRIES];
   logic [NameWidth-1:0] dist_ff   [TABLE_ENTRIES];

   logic [CntW-1:0]      count_ff, dcount_ff;
   logic [CntW-1:0]      scan_ff, dscan_ff;
   logic [IdxW-1:0]      hit_ff, dhit_ff;
   logic                 pair_ff, client_hit_ff, file_hit_ff, dist_hit_ff;
   logic [NameWidth-1:0] rq_client_ff, rq_file_ff, rq_addr_ff, gone_ff;
   logic [PortWidth-1:0] rq_port_ff;
   action_type           action_ff;
   status_type           status_ff;

   logic [NameWidth-1:0] key_mask;
   logic [IdxW-1:0]      sidx, didx;
   logic                 c_eq, f_eq, g_eq, d_eq;
   logic [CntW-1:0]      quota_lim;

   always_comb begin
      key_mask = '0;
      key_mask[KeyW-1:0] = '1;
   end

   assign sidx = scan_ff[IdxW-1:0];
   assign didx = dscan_ff[IdxW-1:0];
   assign c_eq = client_ff[sidx] == rq_client_ff;
   assign f_eq = file_ff[sidx] == rq_file_ff;
   assign g_eq = file_ff[sidx] == gone_ff;
   assign d_eq = dist_ff[didx] == ((action_ff == ACT_REGISTER) ? rq_file_ff : gone_ff);

   always_comb begin
      if ({{(32 - CountWidth){1'b0}}, quota} > TABLE_ENTRIES) begin
         quota_lim = CntW'(TABLE_ENTRIES);
      end else begin
         quota_lim = CntW'(quota);
      end
   end

   always_comb begin
      stat                 = '0;
      stat.action          = action_ff;
      stat.scan_done       = scan_ff >= count_ff;
      stat.pair_found      = pair_ff;
      stat.client_found    = client_hit_ff;
      stat.file_found      = file_hit_ff;
      stat.dist_done       = dscan_ff >= dcount_ff;
      stat.dist_found      = dist_hit_ff;
      stat.shift_done      = scan_ff + CntW'(1) >= count_ff;
      stat.dist_shift_done = dscan_ff + CntW'(1) >= dcount_ff;
      stat.at_quota        = count_ff >= quota_lim;
      stat.dist_full       = dcount_ff >= CntW'(TABLE_ENTRIES);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         dcount_ff <= '0;
         status_ff <= ST_ACK;
      end else begin
         if (cmd.set_status) status_ff <= cmd.status;
         if (cmd.entry_append) count_ff <= count_ff + CntW'(1);
         if (cmd.shift_step && stat.shift_done) count_ff <= count_ff - CntW'(1);
         if (cmd.dist_append) dcount_ff <= dcount_ff + CntW'(1);
         if (cmd.dist_shift && stat.dist_shift_done) dcount_ff <= dcount_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff    <= action_type'(in_action);
         rq_client_ff <= in_client & key_mask;
         rq_file_ff   <= in_file & key_mask;
         rq_addr_ff   <= in_address;
         rq_port_ff   <= in_port;
      end
      if (cmd.scan_clear) begin
         scan_ff       <= '0;
         pair_ff       <= 1'b0;
         client_hit_ff <= 1'b0;
      end else if (cmd.scan_step && !stat.scan_done) begin
         if (action_ff == ACT_DEREG_ALL ? (c_eq && !client_hit_ff)
                                        : (c_eq && f_eq && !pair_ff)) begin
            hit_ff <= sidx;
         end
         if (c_eq && f_eq) pair_ff <= 1'b1;
         if (c_eq) client_hit_ff <= 1'b1;
         if (g_eq) file_hit_ff <= 1'b1;
         scan_ff <= scan_ff + CntW'(1);
      end
      if (cmd.shift_start) begin
         scan_ff <= {{(CntW - IdxW){1'b0}}, hit_ff};
         gone_ff <= file_ff[hit_ff];
      end
      if (cmd.shift_step && !stat.shift_done) begin
         client_ff[sidx] <= client_ff[sidx + IdxW'(1)];
         file_ff[sidx]   <= file_ff[sidx + IdxW'(1)];
         addr_ff[sidx]   <= addr_ff[sidx + IdxW'(1)];
         port_ff[sidx]   <= port_ff[sidx + IdxW'(1)];
         scan_ff         <= scan_ff + CntW'(1);
      end
      if (cmd.file_start) begin
         scan_ff     <= '0;
         file_hit_ff <= 1'b0;
      end
      if (cmd.dist_start) begin
         dscan_ff    <= '0;
         dist_hit_ff <= 1'b0;
      end else if (cmd.dist_step && !stat.dist_done) begin
         if (d_eq && !dist_hit_ff) dhit_ff <= didx;
         if (d_eq) dist_hit_ff <= 1'b1;
         dscan_ff <= dscan_ff + CntW'(1);
      end
      if (cmd.dist_step && stat.dist_done && action_ff != ACT_REGISTER && dist_hit_ff) begin
         dscan_ff <= {{(CntW - IdxW){1'b0}}, dhit_ff};
      end
      if (cmd.dist_shift && !stat.dist_shift_done) begin
         dist_ff[didx] <= dist_ff[didx + IdxW'(1)];
         dscan_ff      <= dscan_ff + CntW'(1);
      end
      if (cmd.entry_append) begin
         client_ff[count_ff[IdxW-1:0]] <= rq_client_ff;
         file_ff[count_ff[IdxW-1:0]]   <= rq_file_ff;
         addr_ff[count_ff[IdxW-1:0]]   <= rq_addr_ff;
         port_ff[count_ff[IdxW-1:0]]   <= rq_port_ff;
      end
      if (cmd.dist_append) dist_ff[dcount_ff[IdxW-1:0]] <= rq_file_ff;
   end

   assign out_status   = status_ff;
   assign out_entries  = CountWidth'(count_ff);
   assign out_distinct = CountWidth'(dcount_ff);

endmodule : krt_datapath
`default_nettype wire

// File: rtl/keyed_registration_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_registration_table
// Compacted table of client and file registrations with a distinct file list.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// req       in         action, client, file, address, port
// rsp       out        status, entries used, distinct files
// csr       in         APB write of entry_quota at address 0
//
// Each entry scan, entry shift and distinct list step advances one entry per
// cycle. A deregister-all repeats search, shift and list update for each
// removed entry.
// One request is in flight at a time; the result word holds until taken.
// Reset is synchronous and clears the counts; stores need no clearing.
// ----------------------------------------------------------------------------
module keyed_registration_table
   import krt_pkg::*;
#(
   parameter int unsigned TABLE_ENTRIES = TableEntriesDefault,
   parameter int unsigned NAME_CHARS    = NameCharsDefault
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   krt_req_if.sink                      req,
   krt_rsp_if.source                    rsp,
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [31:0]             csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);

   logic [CountWidth-1:0] quota_ff;
   cmd_type               cmd;
   stat_type              stat;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         quota_ff <= CountWidth'(QuotaReset);
      end else if (csr_psel && csr_penable && csr_pwrite
                   && csr_paddr == CSR_ENTRY_QUOTA) begin
         quota_ff <= csr_pwdata[CountWidth-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == CSR_ENTRY_QUOTA) csr_prdata[CountWidth-1:0] = quota_ff;
   end

   krt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   krt_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .NAME_CHARS    (NAME_CHARS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .in_action    (req.action),
      .in_client    ({req.client_name_hi, req.client_name_lo}),
      .in_file      ({req.file_name_hi, req.file_name_lo}),
      .in_address   ({req.address_hi, req.address_lo}),
      .in_port      (req.listener_port),
      .quota        (quota_ff),
      .out_status   (rsp.status),
      .out_entries  (rsp.entries_used),
      .out_distinct (rsp.distinct_files)
   );

endmodule : keyed_registration_table
`default_nettype wire
